@@ rtl/glr_pkg.sv @@
// ----------------------------------------------------------------------------
// glr_pkg: shared types and constants for the light direction rotator
// Payload structs, register indexes, fixed-point constants, the CORDIC
// arctangent table and a 16-bit saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package glr_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_LIGHT_ENABLE = 3'd0;
	localparam logic [2:0] REG_GYRO_PRESENT = 3'd1;
	localparam logic [2:0] REG_BASE_DIR_X   = 3'd2;
	localparam logic [2:0] REG_BASE_DIR_Y   = 3'd3;
	localparam logic [2:0] REG_BASE_DIR_Z   = 3'd4;
	localparam logic [2:0] REG_OSC_AMP      = 3'd5;
	localparam logic [2:0] REG_OSC_RATE     = 3'd6;

	// request commands
	localparam logic CMD_GYRO = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [14:0] AMP_RESET  = 15'd715;
	localparam logic [15:0] RATE_RESET = 16'd1074;

	// 2^20 / pi, Q4.11 radians to 32-bit binary angle
	localparam logic signed [35:0] ANGLE_TO_PHASE   = 36'sd333772;
	// 0.7 in Q0.16
	localparam logic signed [17:0] SEVEN_TENTHS_Q16 = 18'sd45875;
	// 1/K at scale 2^30
	localparam logic signed [33:0] CORDIC_GAIN_INIT = 34'sd652032874;
	localparam int                 CordicIters      = 16;

	typedef struct packed {
		logic               cmd;
		logic signed [15:0] pitch_in;
		logic signed [15:0] yaw_in;
		logic        [15:0] dt_us;
	} glr_item_t;

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} glr_dir_t;

	// atan(2^-i) in binary angle units (2^32 per turn)
	function automatic logic [29:0] glr_atan(input logic [3:0] idx);
		logic [29:0] r;
		case (idx)
			4'd0:    r = 30'd536870912;
			4'd1:    r = 30'd316933406;
			4'd2:    r = 30'd167458907;
			4'd3:    r = 30'd85004756;
			4'd4:    r = 30'd42667331;
			4'd5:    r = 30'd21354465;
			4'd6:    r = 30'd10679838;
			4'd7:    r = 30'd5340245;
			4'd8:    r = 30'd2670163;
			4'd9:    r = 30'd1335087;
			4'd10:   r = 30'd667544;
			4'd11:   r = 30'd333772;
			4'd12:   r = 30'd166886;
			4'd13:   r = 30'd83443;
			4'd14:   r = 30'd41722;
			4'd15:   r = 30'd20861;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] glr_sat16(input logic signed [39:0] v);
		logic signed [15:0] r;
		if (v > 40'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -40'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/gyro_light_direction_rotation.sv @@
// ----------------------------------------------------------------------------
// gyro_light_direction_rotation
// Rotates a base light direction by yaw about Y, then pitch about X, using
// one shared CORDIC stage and one shared 36x18 multiplier under a sequencer.
// ----------------------------------------------------------------------------
//  channel | valid/ready         | payload          | role
//  item    | item_valid/_ready   | item_data        | gyro sample or tick in
//  res     | res_valid/_ready    | res_data         | rotated direction out
//  cfg     | cfg_valid/_ready    | cfg_index/_data  | register write
//
//  A gyro request computes two sine/cosine pairs and a tick three, on the
//  single CORDIC stage, with products on the shared multiplier. A request
//  that does not apply leaves item_ready high and produces nothing. Reset
//  is asynchronous and clears phase, control and configuration but for
//  oscillator amplitude and rate, set to defaults. A stalled result sits
//  in the output register while the next request is taken; the sequencer
//  holds in its last step only if that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_light_direction_rotation
	import glr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,

	input  wire logic      item_valid,
	output logic           item_ready,
	input  wire glr_item_t item_data,

	output logic           res_valid,
	input  wire logic      res_ready,
	output glr_dir_t       res_data,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_PH_MUL, S_PH_ADD,
		S_CLD, S_CIT, S_CEND,
		S_AMP_MUL, S_AMP_RND, S_YAW_MUL, S_YAW_RND,
		S_PANG_MUL, S_PANG, S_YANG_MUL, S_YANG,
		S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		K_TICK,
		K_PITCH,
		K_YAW
	} trig_kind_t;

	state_t     state_q;
	trig_kind_t kind_q;
	logic [3:0] iter_q;

	logic               light_enable_q;
	logic               gyro_present_q;
	logic signed [15:0] base_x_q;
	logic signed [15:0] base_y_q;
	logic signed [15:0] base_z_q;
	logic [14:0]        osc_amp_q;
	logic [15:0]        osc_rate_q;
	logic [31:0]        phase_q;
	logic               res_valid_q;
	glr_dir_t           res_data_q;

	logic signed [15:0] pitch_q;
	logic signed [15:0] yaw_q;
	logic [15:0]        dt_q;
	logic [31:0]        ang_q;
	logic [1:0]         quad_q;
	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [31:0] z_q;
	logic signed [17:0] cp_q;
	logic signed [17:0] sp_q;
	logic signed [17:0] cy_q;
	logic signed [17:0] sy_q;
	logic signed [53:0] prod_q;
	logic signed [53:0] acc_q;
	logic signed [34:0] rz_q;
	logic signed [15:0] ox_q;
	logic signed [15:0] oy_q;
	logic signed [15:0] oz_q;

	logic               applies;
	logic signed [35:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [53:0] mul_p;
	logic signed [35:0] ry;
	logic [31:0]        qsum;
	logic [1:0]         quad;
	logic [31:0]        resid;
	logic signed [33:0] dx;
	logic signed [33:0] dy;
	logic signed [31:0] atan_s;
	logic signed [33:0] cc;
	logic signed [33:0] ss;
	logic signed [33:0] cc_r;
	logic signed [33:0] ss_r;
	logic signed [55:0] sum_p;
	logic signed [55:0] sum_x;
	logic signed [55:0] sum_y;
	logic signed [55:0] sum_z;

	assign item_ready = (state_q == S_IDLE);
	assign cfg_ready  = 1'b1;
	assign res_valid  = res_valid_q;
	assign res_data   = res_data_q;

	assign applies = light_enable_q &&
		((item_data.cmd == CMD_TICK) ? !gyro_present_q : gyro_present_q);

	assign ry = {{4{base_y_q[15]}}, base_y_q, 16'd0};

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_PH_MUL: begin
				mul_a = signed'({20'd0, dt_q});
				mul_b = signed'({2'd0, osc_rate_q});
			end
			S_AMP_MUL: begin
				mul_a = signed'({21'd0, osc_amp_q});
				mul_b = sp_q;
			end
			S_YAW_MUL: begin
				mul_a = 36'(pitch_q);
				mul_b = SEVEN_TENTHS_Q16;
			end
			S_PANG_MUL: begin
				mul_a = ANGLE_TO_PHASE;
				mul_b = 18'(pitch_q);
			end
			S_YANG_MUL: begin
				mul_a = ANGLE_TO_PHASE;
				mul_b = 18'(yaw_q);
			end
			S_P1: begin
				mul_a = 36'(base_x_q);
				mul_b = cy_q;
			end
			S_P2: begin
				mul_a = 36'(base_z_q);
				mul_b = sy_q;
			end
			S_P3: begin
				mul_a = 36'(base_z_q);
				mul_b = cy_q;
			end
			S_P4: begin
				mul_a = 36'(base_x_q);
				mul_b = sy_q;
			end
			S_P5: begin
				mul_a = ry;
				mul_b = cp_q;
			end
			S_P6: begin
				mul_a = 36'(rz_q);
				mul_b = sp_q;
			end
			S_P7: begin
				mul_a = ry;
				mul_b = sp_q;
			end
			S_P8: begin
				mul_a = 36'(rz_q);
				mul_b = cp_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// quadrant reduction and CORDIC step
	always_comb begin
		qsum   = ang_q + 32'h2000_0000;
		quad   = qsum[31:30];
		resid  = ang_q - {quad, 30'd0};
		dx     = y_q >>> iter_q;
		dy     = x_q >>> iter_q;
		atan_s = signed'({2'd0, glr_atan(iter_q)});
		case (quad_q)
			2'd0: begin
				cc = x_q;
				ss = y_q;
			end
			2'd1: begin
				cc = -y_q;
				ss = x_q;
			end
			2'd2: begin
				cc = -x_q;
				ss = -y_q;
			end
			default: begin
				cc = y_q;
				ss = -x_q;
			end
		endcase
		cc_r = cc + 34'sd8192;
		ss_r = ss + 34'sd8192;
	end

	// rounding adders
	always_comb begin
		sum_p = 56'(prod_q) + 56'sd32768;
		sum_x = 56'(acc_q) + 56'(prod_q) + 56'sd32768;
		sum_y = 56'(acc_q) - 56'(prod_q) + 56'sd2147483648;
		sum_z = 56'(acc_q) + 56'(prod_q) + 56'sd2147483648;
	end

	// sequencer, configuration, phase and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			kind_q         <= K_TICK;
			iter_q         <= '0;
			light_enable_q <= 1'b0;
			gyro_present_q <= 1'b0;
			base_x_q       <= '0;
			base_y_q       <= '0;
			base_z_q       <= '0;
			osc_amp_q      <= AMP_RESET;
			osc_rate_q     <= RATE_RESET;
			phase_q        <= '0;
			res_valid_q    <= 1'b0;
			res_data_q     <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_LIGHT_ENABLE: light_enable_q <= cfg_data[0];
					REG_GYRO_PRESENT: gyro_present_q <= cfg_data[0];
					REG_BASE_DIR_X:   base_x_q       <= signed'(cfg_data);
					REG_BASE_DIR_Y:   base_y_q       <= signed'(cfg_data);
					REG_BASE_DIR_Z:   base_z_q       <= signed'(cfg_data);
					REG_OSC_AMP:      osc_amp_q      <= cfg_data[14:0];
					REG_OSC_RATE:     osc_rate_q     <= cfg_data;
					default: ;
				endcase
			end

			// load a finished direction once the output register is free
			if (state_q == S_OUT && (!res_valid_q || res_ready)) begin
				res_valid_q      <= 1'b1;
				res_data_q.dir_x <= ox_q;
				res_data_q.dir_y <= oy_q;
				res_data_q.dir_z <= oz_q;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (item_valid && applies) begin
						state_q <= (item_data.cmd == CMD_TICK) ? S_PH_MUL : S_PANG_MUL;
					end
				end
				S_PH_MUL: state_q <= S_PH_ADD;
				S_PH_ADD: begin
					phase_q <= phase_q + prod_q[31:0];
					kind_q  <= K_TICK;
					state_q <= S_CLD;
				end
				S_CLD: begin
					iter_q  <= '0;
					state_q <= S_CIT;
				end
				S_CIT: begin
					iter_q <= iter_q + 4'd1;
					if (iter_q == 4'(CordicIters - 1)) begin
						state_q <= S_CEND;
					end
				end
				S_CEND: begin
					case (kind_q)
						K_TICK:  state_q <= S_AMP_MUL;
						K_PITCH: state_q <= S_YANG_MUL;
						default: state_q <= S_P1;
					endcase
				end
				S_AMP_MUL:  state_q <= S_AMP_RND;
				S_AMP_RND:  state_q <= S_YAW_MUL;
				S_YAW_MUL:  state_q <= S_YAW_RND;
				S_YAW_RND:  state_q <= S_PANG_MUL;
				S_PANG_MUL: state_q <= S_PANG;
				S_PANG: begin
					kind_q  <= K_PITCH;
					state_q <= S_CLD;
				end
				S_YANG_MUL: state_q <= S_YANG;
				S_YANG: begin
					kind_q  <= K_YAW;
					state_q <= S_CLD;
				end
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_P3;
				S_P3: state_q <= S_P4;
				S_P4: state_q <= S_P5;
				S_P5: state_q <= S_P6;
				S_P6: state_q <= S_P7;
				S_P7: state_q <= S_P8;
				S_P8: state_q <= S_P9;
				S_P9: state_q <= S_OUT;
				S_OUT: begin
					// hold until the output register is free
					if (!res_valid_q || res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (state_q)
			S_IDLE: begin
				pitch_q <= item_data.pitch_in;
				yaw_q   <= item_data.yaw_in;
				dt_q    <= item_data.dt_us;
			end
			S_PH_ADD: ang_q <= phase_q + prod_q[31:0];
			S_CLD: begin
				quad_q <= quad;
				z_q    <= signed'(resid);
				x_q    <= CORDIC_GAIN_INIT;
				y_q    <= '0;
			end
			S_CIT: begin
				if (!z_q[31]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_s;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_s;
				end
			end
			S_CEND: begin
				if (kind_q == K_YAW) begin
					cy_q <= cc_r[31:14];
					sy_q <= ss_r[31:14];
				end else begin
					cp_q <= cc_r[31:14];
					sp_q <= ss_r[31:14];
				end
			end
			S_AMP_RND: pitch_q <= glr_sat16(40'(sum_p >>> 16));
			S_YAW_RND: yaw_q   <= 16'(sum_p >>> 16);
			S_PANG:    ang_q   <= prod_q[31:0];
			S_YANG:    ang_q   <= prod_q[31:0];
			S_P2:      acc_q   <= prod_q;
			S_P3:      ox_q    <= glr_sat16(40'(sum_x >>> 16));
			S_P4:      acc_q   <= prod_q;
			S_P5:      rz_q    <= 35'(acc_q - prod_q);
			S_P6:      acc_q   <= prod_q;
			S_P7:      oy_q    <= glr_sat16(40'(sum_y >>> 32));
			S_P8:      acc_q   <= prod_q;
			S_P9:      oz_q    <= glr_sat16(40'(sum_z >>> 32));
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/glr_checker.sv @@
// ----------------------------------------------------------------------------
// glr_checker: port-level checks for the light direction rotator
// Tracks enable and gyro mode from register writes and checks busy
// behavior and result delivery as seen on the ports.
// ----------------------------------------------------------------------------
`default_nettype none

module glr_checker
	import glr_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_ready,
	input wire glr_item_t   item_data,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire glr_dir_t    res_data,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic [2:0]  cfg_index,
	input wire logic [15:0] cfg_data
);

	logic light_q;
	logic gyro_q;
	logic applies;
	logic take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q <= 1'b0;
			gyro_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_LIGHT_ENABLE) begin
				light_q <= cfg_data[0];
			end
			if (cfg_index == REG_GYRO_PRESENT) begin
				gyro_q <= cfg_data[0];
			end
		end
	end

	assign take    = item_valid && item_ready;
	assign applies = light_q && ((item_data.cmd == CMD_TICK) ? !gyro_q : gyro_q);

	// a request that applies starts work
	a_busy_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		take && applies |=> !item_ready)
		else $error("block not busy after an applicable request");

	// a request that does not apply is dropped at once
	a_drop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take && !applies |=> item_ready)
		else $error("block busy after a dropped request");

	// a new result only comes out of a busy sequence
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !$past(item_ready))
		else $error("result appeared without work");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("stalled result changed");

endmodule

bind gyro_light_direction_rotation glr_checker u_glr_checker (.*);

`default_nettype wire
